>>> hw/rtl/srsp_pkg.sv
package srsp_pkg;

    // Colour table size and field widths
    localparam int COLOR_SLOTS = 16;
    localparam int SLOT_W      = 4;
    localparam int POS_W       = 24;

    // Header length and position of the flags byte in a record
    localparam logic [3:0] HEADER_BYTES = 4'd4;
    localparam logic [3:0] REC_FLAG_IDX = 4'd8;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(COLOR_SLOTS - 1);

    // Flag bits in the record flags byte
    localparam int FLAG_STOP_BIT = 0;
    localparam int FLAG_TRIM_BIT = 2;

    // Result kinds
    localparam logic [1:0] KIND_COLOR  = 2'd0;
    localparam logic [1:0] KIND_STITCH = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Stitch kinds
    localparam logic [1:0] SK_NORMAL = 2'd0;
    localparam logic [1:0] SK_STOP   = 2'd1;
    localparam logic [1:0] SK_TRIM   = 2'd2;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One parsed event: an optional colour or stitch result, then an optional end stitch
    typedef struct packed {
        logic              has_main;
        logic [1:0]        main_kind;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        code;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [1:0]        stitch_kind;
        logic              has_end;
    } srsp_evt_t;

endpackage

>>> hw/rtl/srsp_front.sv
module srsp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output srsp_pkg::srsp_evt_t  q_evt
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_COLOR  = 3'd1;
    localparam logic [2:0] PH_COUNT  = 3'd2;
    localparam logic [2:0] PH_REC    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [2:0]                    phase_reg, phase_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic [srsp_pkg::SLOT_W-1:0]   color_reg, color_next;
    logic [15:0]                   records_reg, records_next;
    logic [srsp_pkg::POS_W-1:0]    last_x_reg, last_x_next;
    logic [srsp_pkg::POS_W-1:0]    last_y_reg, last_y_next;
    logic                          end_done_reg, end_done_next;
    logic [7:0]                    record_bytes_reg [0:7];

    logic                          accept;
    logic [2:0]                    phase_eff;
    logic [3:0]                    cnt_eff;
    logic [srsp_pkg::SLOT_W-1:0]   color_eff;
    logic [15:0]                   records_eff;
    logic [srsp_pkg::POS_W-1:0]    last_x_eff;
    logic [srsp_pkg::POS_W-1:0]    last_y_eff;
    logic                          end_done_eff;
    logic                          byte_wr;
    logic [15:0]                   rec_count;
    logic [15:0]                   rec_left;
    logic [srsp_pkg::POS_W-1:0]    rec_x;
    logic [srsp_pkg::POS_W-1:0]    rec_y;
    srsp_pkg::srsp_evt_t           evt;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Start of file returns all state to its reset value before the byte is parsed
    assign phase_eff    = s_tuser ? PH_HEADER : phase_reg;
    assign cnt_eff      = s_tuser ? 4'd0 : cnt_reg;
    assign color_eff    = s_tuser ? '0 : color_reg;
    assign records_eff  = s_tuser ? 16'd0 : records_reg;
    assign last_x_eff   = s_tuser ? '0 : last_x_reg;
    assign last_y_eff   = s_tuser ? '0 : last_y_reg;
    assign end_done_eff = s_tuser ? 1'b0 : end_done_reg;

    assign rec_count = records_eff | {8'd0, s_tdata};
    assign rec_left  = records_eff - 16'd1;
    assign rec_x     = {record_bytes_reg[0], record_bytes_reg[1], record_bytes_reg[2]};
    assign rec_y     = {record_bytes_reg[4], record_bytes_reg[5], record_bytes_reg[6]};

    // Parse one byte: update the phase and build the event for the queue
    always_comb begin
        phase_next    = phase_eff;
        cnt_next      = cnt_eff;
        color_next    = color_eff;
        records_next  = records_eff;
        last_x_next   = last_x_eff;
        last_y_next   = last_y_eff;
        end_done_next = end_done_eff;
        byte_wr       = 1'b0;
        evt           = '0;
        evt.pos_x     = last_x_eff;
        evt.pos_y     = last_y_eff;

        if (s_tlast) begin
            if (!end_done_eff) begin
                evt.has_end   = 1'b1;
                end_done_next = 1'b1;
                phase_next    = PH_DONE;
            end
        end else begin
            unique case (phase_eff)
                PH_HEADER: begin
                    cnt_next = cnt_eff + 4'd1;
                    if (cnt_next >= srsp_pkg::HEADER_BYTES) begin
                        cnt_next   = 4'd0;
                        color_next = '0;
                        phase_next = PH_COLOR;
                    end
                end
                PH_COLOR: begin
                    if (cnt_eff == 4'd0) begin
                        cnt_next = 4'd1;
                    end else begin
                        cnt_next      = 4'd0;
                        evt.has_main  = 1'b1;
                        evt.main_kind = srsp_pkg::KIND_COLOR;
                        evt.slot      = color_eff;
                        evt.code      = s_tdata;
                        evt.pos_x     = '0;
                        evt.pos_y     = '0;
                        if (color_eff >= srsp_pkg::LAST_SLOT) begin
                            phase_next = PH_COUNT;
                        end else begin
                            color_next = color_eff + 1'b1;
                        end
                    end
                end
                PH_COUNT: begin
                    if (cnt_eff == 4'd0) begin
                        records_next = {s_tdata, 8'd0};
                        cnt_next     = 4'd1;
                    end else begin
                        records_next = rec_count;
                        cnt_next     = 4'd0;
                        if (rec_count == 16'd0) begin
                            evt.has_end   = 1'b1;
                            end_done_next = 1'b1;
                            phase_next    = PH_DONE;
                        end else begin
                            phase_next = PH_REC;
                        end
                    end
                end
                PH_REC: begin
                    if (cnt_eff < srsp_pkg::REC_FLAG_IDX) begin
                        byte_wr  = 1'b1;
                        cnt_next = cnt_eff + 4'd1;
                    end else begin
                        evt.has_main  = 1'b1;
                        evt.main_kind = srsp_pkg::KIND_STITCH;
                        evt.pos_x     = rec_x;
                        evt.pos_y     = rec_y;
                        if (s_tdata[srsp_pkg::FLAG_STOP_BIT]) begin
                            evt.stitch_kind = srsp_pkg::SK_STOP;
                        end else if (s_tdata[srsp_pkg::FLAG_TRIM_BIT]) begin
                            evt.stitch_kind = srsp_pkg::SK_TRIM;
                        end else begin
                            evt.stitch_kind = srsp_pkg::SK_NORMAL;
                        end
                        last_x_next  = rec_x;
                        last_y_next  = rec_y;
                        cnt_next     = 4'd0;
                        records_next = rec_left;
                        if (rec_left == 16'd0) begin
                            evt.has_end   = 1'b1;
                            end_done_next = 1'b1;
                            phase_next    = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign q_push = accept && (evt.has_main || evt.has_end);
    assign q_evt  = evt;

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            cnt_reg      <= 4'd0;
            color_reg    <= '0;
            records_reg  <= 16'd0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            end_done_reg <= 1'b0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            color_reg    <= color_next;
            records_reg  <= records_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            end_done_reg <= end_done_next;
        end
    end

    // Capture record bytes; always written before they are read
    always_ff @(posedge aclk) begin
        if (accept && byte_wr) begin
            record_bytes_reg[cnt_eff[2:0]] <= s_tdata;
        end
    end

endmodule

>>> hw/rtl/srsp_queue.sv
module srsp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  srsp_pkg::srsp_evt_t  push_evt,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output srsp_pkg::srsp_evt_t  pop_evt
);

    srsp_pkg::srsp_evt_t             entry_reg [0:srsp_pkg::QUEUE_DEPTH-1];
    logic [srsp_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [srsp_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [srsp_pkg::QUEUE_CW-1:0]   count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == srsp_pkg::QUEUE_CW'(srsp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_evt   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store events
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

>>> hw/rtl/srsp_back.sv
module srsp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  srsp_pkg::srsp_evt_t  q_evt,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    logic                              valid_reg, valid_next;
    logic [1:0]                        kind_reg, kind_next;
    logic [srsp_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [7:0]                        code_reg, code_next;
    logic [srsp_pkg::POS_W-1:0]        x_reg, x_next;
    logic [srsp_pkg::POS_W-1:0]        y_reg, y_next;
    logic [1:0]                        sk_reg, sk_next;
    logic                              last_reg, last_next;
    logic                              pend_reg, pend_next;
    logic [srsp_pkg::POS_W-1:0]        pend_x_reg, pend_x_next;
    logic [srsp_pkg::POS_W-1:0]        pend_y_reg, pend_y_next;
    logic                              slot_free;

    assign slot_free = !valid_reg || m_tready;
    assign q_pop     = slot_free && !pend_reg && q_not_empty;

    // Load the output register from the pending end stitch or the next event
    always_comb begin
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        slot_next   = slot_reg;
        code_next   = code_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        sk_next     = sk_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        pend_x_next = pend_x_reg;
        pend_y_next = pend_y_reg;

        if (slot_free) begin
            valid_next = 1'b0;
            if (pend_reg) begin
                valid_next = 1'b1;
                kind_next  = srsp_pkg::KIND_END;
                slot_next  = '0;
                code_next  = 8'd0;
                x_next     = pend_x_reg;
                y_next     = pend_y_reg;
                sk_next    = srsp_pkg::SK_NORMAL;
                last_next  = 1'b1;
                pend_next  = 1'b0;
            end else if (q_not_empty) begin
                valid_next = 1'b1;
                x_next     = q_evt.pos_x;
                y_next     = q_evt.pos_y;
                if (q_evt.has_main) begin
                    kind_next   = q_evt.main_kind;
                    slot_next   = q_evt.slot;
                    code_next   = q_evt.code;
                    sk_next     = q_evt.stitch_kind;
                    last_next   = !q_evt.has_end;
                    pend_next   = q_evt.has_end;
                    pend_x_next = q_evt.pos_x;
                    pend_y_next = q_evt.pos_y;
                end else begin
                    kind_next = srsp_pkg::KIND_END;
                    slot_next = '0;
                    code_next = 8'd0;
                    sk_next   = srsp_pkg::SK_NORMAL;
                    last_next = 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        slot_reg   <= slot_next;
        code_reg   <= code_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        sk_reg     <= sk_next;
        last_reg   <= last_next;
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, sk_reg, y_reg, x_reg, code_reg, slot_reg};

endmodule

>>> hw/rtl/stitch_record_stream_parser.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  one file byte, start-of-file flag, end marker
// m_        out        m_tvalid/m_tready  colour entry, stitch record or end stitch
//
// The parser takes one byte per cycle while the event queue is not full; each byte is
// classified in the cycle it is accepted. Results pass through a 4-entry event queue to a
// registered output stage. The last record yields two results, a stitch and an end stitch,
// both taken from one queue entry. aresetn is synchronous; it clears control state only and
// no clearing pass follows. s_tready falls only while the event queue is full.
module stitch_record_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] file_start
    input  logic        s_tlast,   // end_marker
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] color_slot, [11:4] color_code, [35:12] pos_x, [59:36] pos_y,
    // [61:60] stitch_kind, [63:62] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] item_kind
    output logic        m_tlast    // run_last
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_not_empty;
    srsp_pkg::srsp_evt_t  push_evt;
    srsp_pkg::srsp_evt_t  pop_evt;

    srsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_evt    (push_evt)
    );

    srsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_evt  (push_evt),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_evt   (pop_evt)
    );

    srsp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_evt       (pop_evt),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> tb/stitch_record_stream_parser_tb.sv
module stitch_record_stream_parser_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int ITEM_TARGET = 700;
    localparam int QUIET_ITEMS = 150;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COLOR,
        PH_COUNT,
        PH_RECORD,
        PH_DONE
    } parse_phase_t;

    // One parsed result as it should leave the block
    typedef struct {
        logic [1:0]                  kind;
        logic [srsp_pkg::SLOT_W-1:0] slot;
        logic [7:0]                  code;
        logic [srsp_pkg::POS_W-1:0]  x;
        logic [srsp_pkg::POS_W-1:0]  y;
        logic [1:0]                  sk;
        logic                        last;
    } parsed_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Shadow copy of the parser state
    parse_phase_t                phase;
    logic [3:0]                  byte_cnt;
    logic [srsp_pkg::SLOT_W-1:0] color_ctr;
    logic [15:0]                 recs_left;
    logic [7:0]                  rec_buf [8];
    logic [srsp_pkg::POS_W-1:0]  last_x;
    logic [srsp_pkg::POS_W-1:0]  last_y;
    logic                        end_done;

    parsed_t parsed_q [$];
    parsed_t step_q [$];
    parsed_t head_item;

    int   mismatches  = 0;
    int   items_sent  = 0;
    int   cycle_count = 0;
    logic idle_en     = 1'b1;
    logic stall_en    = 1'b1;

    stitch_record_stream_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------

    function void clear_parser();
        phase     = PH_HEADER;
        byte_cnt  = '0;
        color_ctr = '0;
        recs_left = '0;
        for (int i = 0; i < 8; i++) rec_buf[i] = 8'h00;
        last_x    = '0;
        last_y    = '0;
        end_done  = 1'b0;
    endfunction

    function automatic parsed_t make_item(logic [1:0] kind,
                                          logic [srsp_pkg::SLOT_W-1:0] slot,
                                          logic [7:0] code,
                                          logic [srsp_pkg::POS_W-1:0] x,
                                          logic [srsp_pkg::POS_W-1:0] y,
                                          logic [1:0] sk);
        parsed_t r;
        r.kind = kind;
        r.slot = slot;
        r.code = code;
        r.x    = x;
        r.y    = y;
        r.sk   = sk;
        r.last = 1'b0;
        return r;
    endfunction

    // Close the file with an end stitch at the last position
    function void emit_end_stitch();
        step_q.push_back(make_item(srsp_pkg::KIND_END, '0, '0, last_x, last_y,
                                   srsp_pkg::SK_NORMAL));
        end_done = 1'b1;
        phase    = PH_DONE;
    endfunction

    function void parse_item(logic [7:0] b, logic start, logic endm);
        logic [srsp_pkg::POS_W-1:0] x;
        logic [srsp_pkg::POS_W-1:0] y;
        logic [1:0]                 sk;
        parsed_t                    r;
        step_q.delete();
        if (start) clear_parser();
        if (endm) begin
            if (!end_done) emit_end_stitch();
        end else begin
            case (phase)
                PH_HEADER: begin
                    byte_cnt = byte_cnt + 4'd1;
                    if (byte_cnt >= srsp_pkg::HEADER_BYTES) begin
                        byte_cnt  = '0;
                        color_ctr = '0;
                        phase     = PH_COLOR;
                    end
                end
                PH_COLOR: begin
                    // pad byte first, colour number second
                    if (byte_cnt == 4'd0) begin
                        byte_cnt = 4'd1;
                    end else begin
                        byte_cnt = '0;
                        step_q.push_back(make_item(srsp_pkg::KIND_COLOR, color_ctr, b,
                                                   '0, '0, srsp_pkg::SK_NORMAL));
                        if (color_ctr >= srsp_pkg::LAST_SLOT) phase = PH_COUNT;
                        else color_ctr = color_ctr + 1'b1;
                    end
                end
                PH_COUNT: begin
                    if (byte_cnt == 4'd0) begin
                        recs_left = {b, 8'h00};
                        byte_cnt  = 4'd1;
                    end else begin
                        recs_left = recs_left | {8'h00, b};
                        byte_cnt  = '0;
                        if (recs_left == 16'd0) emit_end_stitch();
                        else phase = PH_RECORD;
                    end
                end
                PH_RECORD: begin
                    if (byte_cnt < srsp_pkg::REC_FLAG_IDX) begin
                        rec_buf[byte_cnt[2:0]] = b;
                        byte_cnt = byte_cnt + 4'd1;
                    end else begin
                        x = {rec_buf[0], rec_buf[1], rec_buf[2]};
                        y = {rec_buf[4], rec_buf[5], rec_buf[6]};
                        // stop wins over trim
                        if (b[srsp_pkg::FLAG_STOP_BIT]) sk = srsp_pkg::SK_STOP;
                        else if (b[srsp_pkg::FLAG_TRIM_BIT]) sk = srsp_pkg::SK_TRIM;
                        else sk = srsp_pkg::SK_NORMAL;
                        step_q.push_back(make_item(srsp_pkg::KIND_STITCH, '0, '0, x, y, sk));
                        last_x    = x;
                        last_y    = y;
                        byte_cnt  = '0;
                        recs_left = recs_left - 16'd1;
                        if (recs_left == 16'd0) emit_end_stitch();
                    end
                end
                default: ;
            endcase
        end
        // mark the final result of this transaction
        for (int i = 0; i < step_q.size(); i++) begin
            r = step_q[i];
            r.last = (i == step_q.size() - 1);
            parsed_q.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Lean towards the 24-bit extremes
    function automatic logic [srsp_pkg::POS_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [7:0] b, input logic start, input logic endm);
        if (idle_en) begin
            while ($urandom_range(0, 99) < 33) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        s_tlast  <= endm;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        parse_item(b, start, endm);
        items_sent++;
    endtask

    // Hold the sender until every pending result has come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (parsed_q.size() != 0);
    endtask

    // Header, colour table, count, then the given number of records
    task automatic send_file(input logic [15:0] count, input int recs);
        logic [srsp_pkg::POS_W-1:0] x;
        logic [srsp_pkg::POS_W-1:0] y;
        send_item(rand_byte(), 1'b1, 1'b0);
        repeat (3) send_item(rand_byte(), 1'b0, 1'b0);
        repeat (srsp_pkg::COLOR_SLOTS * 2) send_item(rand_byte(), 1'b0, 1'b0);
        send_item(count[15:8], 1'b0, 1'b0);
        send_item(count[7:0], 1'b0, 1'b0);
        repeat (recs) begin
            x = pick_coord();
            y = pick_coord();
            send_item(x[23:16], 1'b0, 1'b0);
            send_item(x[15:8], 1'b0, 1'b0);
            send_item(x[7:0], 1'b0, 1'b0);
            send_item(rand_byte(), 1'b0, 1'b0);
            send_item(y[23:16], 1'b0, 1'b0);
            send_item(y[15:8], 1'b0, 1'b0);
            send_item(y[7:0], 1'b0, 1'b0);
            send_item(rand_byte(), 1'b0, 1'b0);
            send_item(rand_byte(), 1'b0, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_end_marker_states();
        // end marker straight after reset gives an end stitch at the origin
        send_item(rand_byte(), 1'b0, 1'b1);
        // bytes and a second marker after the end stitch give nothing
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(rand_byte(), 1'b0, 1'b1);
        // file start and end marker on one transaction
        send_item(rand_byte(), 1'b1, 1'b1);
        // end marker part-way through the header
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(rand_byte(), 1'b0, 1'b1);
    endtask

    task automatic test_zero_count();
        send_file(16'h0000, 0);
        // trailing bytes and a late marker are dropped
        send_item(rand_byte(), 1'b0, 1'b0);
        send_item(rand_byte(), 1'b0, 1'b0);
        send_item(rand_byte(), 1'b0, 1'b1);
    endtask

    task automatic test_last_record();
        send_file(16'h0001, 1);
        wait_drain();
    endtask

    task automatic test_early_end_in_records();
        // all count bits set, cut off mid-record
        send_file(16'hFFFF, 2);
        repeat (4) send_item(rand_byte(), 1'b0, 1'b0);
        send_item(rand_byte(), 1'b0, 1'b1);
    endtask

    task automatic test_random_files();
        int first;
        int mode;
        int recs;
        int n;
        first = items_sent;
        while (items_sent < ITEM_TARGET) begin
            // open with a stretch free of idling on both sides
            idle_en  = (items_sent - first) >= QUIET_ITEMS;
            stall_en = (items_sent - first) >= QUIET_ITEMS;
            mode = $urandom_range(0, 99);
            if (mode < 70) begin
                recs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
                send_file(16'(recs), recs);
                if ($urandom_range(0, 1)) begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_item(rand_byte(), 1'b0, 1'b0);
                end
                if ($urandom_range(0, 1)) send_item(rand_byte(), 1'b0, 1'b1);
            end else if (mode < 80) begin
                // truncated file: cut short anywhere from the header to the first record
                n = $urandom_range(1, 40);
                send_item(rand_byte(), 1'b1, 1'b0);
                repeat (n - 1) send_item(rand_byte(), 1'b0, 1'b0);
                send_item(rand_byte(), 1'b0, 1'b1);
            end else if (mode < 90) begin
                // random count, zero to three records, then up to eight stray bytes
                recs = $urandom_range(0, 3);
                send_file({rand_byte(), rand_byte()}, recs);
                n = $urandom_range(0, 8);
                repeat (n) send_item(rand_byte(), 1'b0, 1'b0);
                if ($urandom_range(0, 9) < 7) send_item(rand_byte(), 1'b0, 1'b1);
            end else begin
                n = $urandom_range(5, 20);
                repeat (n) send_item(rand_byte(), $urandom_range(0, 9) == 0,
                                     $urandom_range(0, 9) == 0);
            end
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // Compare each result transaction with the oldest pending one
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (parsed_q.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata, 64'd0);
            end else begin
                head_item = parsed_q.pop_front();
                check_field("item_kind", m_tuser, head_item.kind);
                check_field("color_slot", m_tdata[3:0], head_item.slot);
                check_field("color_code", m_tdata[11:4], head_item.code);
                check_field("pos_x", m_tdata[35:12], head_item.x);
                check_field("pos_y", m_tdata[59:36], head_item.y);
                check_field("stitch_kind", m_tdata[61:60], head_item.sk);
                check_field("tdata padding", m_tdata[63:62], 64'd0);
                check_field("run_last", m_tlast, head_item.last);
            end
        end
        m_tready <= !stall_en || ($urandom_range(0, 99) >= 33);
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        clear_parser();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_end_marker_states();
        test_zero_count();
        test_last_record();
        test_early_end_in_records();
        test_random_files();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && parsed_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
